@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

@@ rtl/fsoc_pkg.sv @@
`timescale 1ns / 1ps
package fsoc_pkg;
  localparam int unsigned OffW = 40;
  localparam int unsigned LenW = 16;
  localparam int unsigned CfgW = 40;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned SumW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TRANSFER_LENGTH = 3'd0,
    REG_SYMBOL_SIZE     = 3'd1,
    REG_ALIGNMENT       = 3'd2,
    REG_SRC_BLOCKS      = 3'd3,
    REG_SUB_BLOCKS      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [OffW-1:0] byte_offset;
    logic [LenW-1:0] segment_length;
    logic            past_end;
    logic            bad_block;
    logic            last_segment;
  } seg_t;

  typedef struct packed {
    logic [7:0]  block_number;
    logic [15:0] symbol_index;
  } req_t;

  // derived partition
  typedef struct packed {
    logic [OffW-1:0] f;
    logic [LenW-1:0] t;
    logic [3:0]      al;
    logic [8:0]      z;
    logic [6:0]      n;
    logic            ok;
    logic [LenW-1:0] kl;
    logic [LenW-1:0] ks;
    logic [8:0]      zl;
    logic [LenW-1:0] tl;
    logic [LenW-1:0] ts;
    logic [6:0]      nl;
  } part_t;
endpackage

@@ rtl/fsoc_stream_if.sv @@
`timescale 1ns / 1ps
interface fsoc_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/fsoc_divider.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module fsoc_divider #(
  parameter int unsigned W = 41
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(W + 1);
  logic [W-1:0] quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [W:0] trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};
    if (start_i) begin
      quo_d = num_i; rem_d = '0; den_d = den_i; cnt_d = CntW'(W); busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end
  assign done_o = done_q;
  assign quo_o = quo_q;
  assign rem_o = rem_q;
endmodule

@@ rtl/fsoc_partition.sv @@
`timescale 1ns / 1ps
// Derives the partition after every register write with a shared divider.
module fsoc_partition
  import fsoc_pkg::*;
#(
  parameter int unsigned MAX_SUB_BLOCKS    = 64,
  parameter int unsigned MAX_BLOCK_SYMBOLS = 56403,
  parameter int unsigned MAX_BLOCKS        = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output logic               busy_o,
  output part_t              part_o
);
  localparam int unsigned DW = 41;
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_KT = 5'b00010, S_ZB = 5'b00100,
    S_NB = 5'b01000, S_DONE = 5'b10000
  } st_e;

  st_e st_q, st_d;
  logic [CfgW-1:0] f_q;
  logic [15:0] t_raw_q;
  logic [3:0] al_raw_q;
  logic [8:0] z_raw_q;
  logic [6:0] n_raw_q;
  logic pend_q;
  part_t part_q, part_d;
  logic [3:0] al;
  logic [15:0] t;
  logic [8:0] z;
  logic [6:0] n;
  logic start;
  logic [DW-1:0] num, den, quo, rem;
  logic done;

  always_comb begin
    if (al_raw_q >= 4'd8) al = 4'd8;
    else if (al_raw_q >= 4'd4) al = 4'd4;
    else if (al_raw_q >= 4'd2) al = 4'd2;
    else al = 4'd1;
    if (t_raw_q < {12'd0, al}) t = {12'd0, al};
    else t = t_raw_q & ~(16'({12'd0, al}) - 16'd1);
    if (z_raw_q == '0) z = 9'd1;
    else if (z_raw_q > 9'(MAX_BLOCKS)) z = 9'(MAX_BLOCKS);
    else z = z_raw_q;
    if (n_raw_q == '0) n = 7'd1;
    else if (n_raw_q > 7'(MAX_SUB_BLOCKS)) n = 7'(MAX_SUB_BLOCKS);
    else n = n_raw_q;
  end

  always_comb begin
    st_d = st_q; part_d = part_q; start = 1'b0;
    num = '0; den = 41'd1;
    case (st_q)
      S_IDLE: if (pend_q) begin
        st_d = S_KT; start = 1'b1;
        num = {1'b0, f_q} + 41'(t) - 41'd1; den = 41'(t);
        part_d.f = f_q; part_d.t = t; part_d.al = al; part_d.z = z; part_d.n = n;
      end
      S_KT: begin
        num = quo; den = 41'(part_q.z);
        if (done) begin start = 1'b1; st_d = S_ZB; end
      end
      S_ZB: begin
        num = 41'(part_q.t >> (part_q.al[3] ? 3 : part_q.al[2] ? 2 : part_q.al[1] ? 1 : 0));
        den = 41'(part_q.n);
        if (done) begin
          start = 1'b1; st_d = S_NB;
          part_d.ok = (rem != '0 ? quo + 41'd1 : quo) <= 41'(MAX_BLOCK_SYMBOLS);
          part_d.ks = quo[15:0];
          part_d.kl = rem != '0 ? quo[15:0] + 16'd1 : 16'd0;
          part_d.zl = rem[8:0];
        end
      end
      S_NB: if (done) begin
        st_d = S_DONE;
        part_d.ts = quo[15:0];
        part_d.tl = rem != '0 ? quo[15:0] + 16'd1 : 16'd0;
        part_d.nl = rem[6:0];
      end
      S_DONE: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  fsoc_divider #(.W(DW)) u_div (
    .clk_i, .rst_ni, .start_i(start), .num_i(num), .den_i(den),
    .done_o(done), .quo_o(quo), .rem_o(rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; pend_q <= 1'b1;
      f_q <= 40'd1; t_raw_q <= 16'd1; al_raw_q <= 4'd1; z_raw_q <= 9'd1; n_raw_q <= 7'd1;
      part_q <= '0;
    end else begin
      st_q <= st_d; part_q <= part_d;
      if (st_q == S_IDLE && pend_q) pend_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_TRANSFER_LENGTH: begin f_q <= cfg_wdata_i; pend_q <= 1'b1; end
          REG_SYMBOL_SIZE: begin t_raw_q <= cfg_wdata_i[15:0]; pend_q <= 1'b1; end
          REG_ALIGNMENT: begin al_raw_q <= cfg_wdata_i[3:0]; pend_q <= 1'b1; end
          REG_SRC_BLOCKS: begin z_raw_q <= cfg_wdata_i[8:0]; pend_q <= 1'b1; end
          REG_SUB_BLOCKS: begin n_raw_q <= cfg_wdata_i[6:0]; pend_q <= 1'b1; end
          default: ;
        endcase
      end
    end
  end

  assign busy_o = pend_q || st_q != S_IDLE || cfg_we_i;
  assign part_o = part_q;
endmodule

@@ rtl/fsoc_segment_seq.sv @@
`timescale 1ns / 1ps
// Per-transaction sequencer: one shared multiply-add unit steps through
// the base offset, then one segment per sub-block.
module fsoc_segment_seq
  import fsoc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_busy_i,
  input  part_t part_i,
  fsoc_stream_if.sink   req,
  fsoc_stream_if.source seg
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_B0 = 6'b000010, S_B1 = 6'b000100,
    S_U = 6'b001000, S_OFF = 6'b010000, S_OUT = 6'b100000
  } st_e;

  st_e st_q, st_d;
  logic [7:0] sbn_q, sbn_d;
  logic [15:0] esi_q, esi_d, k_q, k_d;
  logic [6:0] j_q, j_d;
  logic [SumW-1:0] acc_q, acc_d, base_q, base_d, blk_q, blk_d;
  logic [SumW-1:0] run_q, run_d;
  seg_t out_q, out_d;
  logic ovalid_q, ovalid_d;
  // shared unit
  logic [31:0] ma, mb;
  logic [SumW-1:0] madd, mres;
  logic [15:0] sz;
  logic past, islong;
  logic [SumW-1:0] offs, endp;

  assign mres = SumW'(ma) * SumW'(mb) + madd;
  assign islong = j_q < part_i.nl;
  assign sz = islong ? part_i.tl : part_i.ts;

  always_comb begin
    st_d = st_q; sbn_d = sbn_q; esi_d = esi_q; k_d = k_q; j_d = j_q;
    acc_d = acc_q; base_d = base_q; blk_d = blk_q; run_d = run_q;
    out_d = out_q; ovalid_d = ovalid_q;
    ma = '0; mb = '0; madd = '0;
    offs = base_q + (acc_q << (part_i.al[3] ? 3 : part_i.al[2] ? 2 : part_i.al[1] ? 1 : 0));
    endp = offs + SumW'(sz) * SumW'(part_i.al);
    past = 1'b0;
    if (ovalid_q && seg.ready) ovalid_d = 1'b0;
    case (st_q)
      S_IDLE: if (req.valid && !cfg_busy_i) begin
        sbn_d = req.payload.block_number; esi_d = req.payload.symbol_index;
        if (!part_i.ok || {1'b0, req.payload.block_number} >= part_i.z) begin
          out_d = '{byte_offset: '0, segment_length: '0, past_end: 1'b0,
                    bad_block: 1'b1, last_segment: 1'b1};
          ovalid_d = 1'b1; st_d = S_OUT;
        end else st_d = S_B0;
      end
      S_B0: begin
        // blocks before this one in symbols
        if ({1'b0, sbn_q} < part_i.zl) begin
          ma = 32'(sbn_q); mb = 32'(part_i.kl); k_d = part_i.kl;
        end else begin
          // long blocks are one symbol longer than short ones
          ma = 32'(sbn_q); mb = 32'(part_i.ks); k_d = part_i.ks;
          madd = SumW'(part_i.zl);
        end
        blk_d = mres; st_d = S_B1; j_d = '0; run_d = '0;
      end
      S_B1: begin
        ma = blk_q[31:0]; mb = 32'(part_i.t);
        base_d = mres; st_d = S_U;
      end
      S_U: begin
        // run_q: sub-symbol units of earlier sub-blocks
        ma = 32'(esi_q); mb = 32'(sz); madd = run_q;
        acc_d = mres; st_d = S_OFF;
      end
      S_OFF: if (!ovalid_q || seg.ready) begin
        past = esi_q >= k_q || offs >= SumW'(part_i.f);
        out_d.byte_offset = offs[OffW-1:0];
        out_d.past_end = past;
        out_d.bad_block = 1'b0;
        out_d.last_segment = (7'(j_q + 7'd1) == part_i.n);
        if (past) out_d.segment_length = '0;
        else if (endp >= SumW'(part_i.f))
          out_d.segment_length = 16'(SumW'(part_i.f) - offs);
        else out_d.segment_length = 16'(SumW'(sz) * SumW'(part_i.al));
        ovalid_d = 1'b1;
        ma = 32'(k_q); mb = 32'(sz); madd = run_q;
        run_d = mres;
        j_d = j_q + 7'd1;
        st_d = out_d.last_segment ? S_OUT : S_U;
      end
      S_OUT: if (!ovalid_q || seg.ready) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d; ovalid_q <= ovalid_d;
    end
  end
  always_ff @(posedge clk_i) begin
    sbn_q <= sbn_d; esi_q <= esi_d; k_q <= k_d; j_q <= j_d; acc_q <= acc_d;
    base_q <= base_d; blk_q <= blk_d; run_q <= run_d; out_q <= out_d;
  end

  assign req.ready = (st_q == S_IDLE) && !cfg_busy_i;
  assign seg.valid = ovalid_q;
  assign seg.payload = out_q;
endmodule

@@ rtl/fountain_symbol_offset_calc_core.sv @@
`timescale 1ns / 1ps
// Source-symbol segment addresser.
// Input channel req_in carries block_number and symbol_index; output channel
// seg_out carries one segment transaction per sub-block (byte_offset,
// segment_length, past_end, bad_block, last_segment). A bad block number
// or an invalid partition gives a single flagged transaction.
// Configuration: cfg_we_i/cfg_idx_i/cfg_wdata_i write registers; each write
// to one of the five registers starts a partition recompute through a shared
// restoring divider, during which req_in is not ready.
// Per input: setup states S_B0 and S_B1, then states S_U and S_OFF for each
// sub-block through the shared multiply-add unit; the next input is accepted
// only after the last segment (or the bad-block flag) has been taken.
// One item at a time.
// After reset the defaults (all registers 1) are derived first.
// A stalled receiver holds the output register; the sequencer waits.
`include "assert_macros.svh"
module fountain_symbol_offset_calc_core
  import fsoc_pkg::*;
#(
  parameter int unsigned MAX_SUB_BLOCKS    = 64,
  parameter int unsigned MAX_BLOCK_SYMBOLS = 56403,
  parameter int unsigned MAX_BLOCKS        = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  fsoc_stream_if.sink        req_in,
  fsoc_stream_if.source      seg_out
);
  part_t part;
  logic cfg_busy;

  fsoc_partition #(
    .MAX_SUB_BLOCKS(MAX_SUB_BLOCKS), .MAX_BLOCK_SYMBOLS(MAX_BLOCK_SYMBOLS),
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_part (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .busy_o(cfg_busy), .part_o(part)
  );

  fsoc_segment_seq u_seq (
    .clk_i, .rst_ni, .cfg_busy_i(cfg_busy), .part_i(part),
    .req(req_in), .seg(seg_out)
  );

  `ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni, req_in.valid && req_in.ready && cfg_busy,
    "input accepted during recompute")
  `ASSERT_IMPL(a_bad_is_last, clk_i, rst_ni,
    !(seg_out.valid && seg_out.payload.bad_block) || seg_out.payload.last_segment,
    "bad block not last")
  `ASSERT_IMPL(a_past_zero, clk_i, rst_ni,
    !(seg_out.valid && seg_out.payload.past_end) || seg_out.payload.segment_length == '0,
    "past-end segment with length")
endmodule
